// ===== src/multi_exp_model_with_gradient_macros.svh =====
// ----------------------------------------------------------------------------
// multi-exponential model: assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef MULTI_EXP_MODEL_WITH_GRADIENT_MACROS_SVH
`define MULTI_EXP_MODEL_WITH_GRADIENT_MACROS_SVH
`ifndef SYNTHESIS
`define MEX_ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle check failed");
`define MEX_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");
`else
`define MEX_ASSERT_SAME(label, clk, rst, a, c)
`define MEX_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== src/mex_pkg.sv =====
// ----------------------------------------------------------------------------
// mex_pkg
// widths, register codes, slot codes and the exponent table
// ----------------------------------------------------------------------------
`default_nettype none
package mex_pkg;

  localparam int DEF_MAX_TERMS = 3;

  localparam int X_W     = 31;   // time value, unsigned q11.20
  localparam int R_W     = 31;   // rate, unsigned q11.20
  localparam int A_W     = 32;   // amplitude / offset, signed q12.20
  localparam int V_W     = 32;   // result value
  localparam int P_W     = X_W + R_W;
  localparam int EXP_BITS = 24;
  localparam int ACC_W   = 31;
  localparam int T_W     = 30;
  localparam int E_W     = 21;
  localparam int SIG_W   = 34;
  localparam int MP_W    = SIG_W + E_W + 1;
  localparam int M_W     = MP_W - 20;
  localparam int ML_W    = 18;
  localparam int MH_W    = M_W - ML_W;
  localparam int PLO_W   = X_W + ML_W;
  localparam int PHI_W   = X_W + 1 + MH_W;
  localparam int DP_W    = 69;
  localparam int D_W     = DP_W - 20;
  localparam int Y_W     = 38;

  localparam logic [V_W-1:0] ONE_Q20 = 32'd1048576;

  typedef enum logic [2:0] {
    REG_NUM_TERMS,
    REG_OFFSET,
    REG_AMP0,
    REG_RATE0,
    REG_AMP1,
    REG_RATE1,
    REG_AMP2,
    REG_RATE2
  } cfg_reg_t;

  localparam logic [2:0] SLOT_Y      = 3'd0;
  localparam logic [2:0] SLOT_DOFS   = 3'd1;
  localparam logic [2:0] SLOT_DAMP0  = 3'd2;
  localparam logic [2:0] SLOT_DRATE0 = 3'd3;

  // round(2^30 * exp(-2^(b-20)))
  function automatic logic [T_W-1:0] exp_coef(input logic [4:0] b);
    logic [T_W-1:0] t;
    unique case (b)
      5'd0:  t = 30'd1073740800;
      5'd1:  t = 30'd1073739776;
      5'd2:  t = 30'd1073737728;
      5'd3:  t = 30'd1073733632;
      5'd4:  t = 30'd1073725440;
      5'd5:  t = 30'd1073708544;
      5'd6:  t = 30'd1073676290;
      5'd7:  t = 30'd1073610760;
      5'd8:  t = 30'd1073479712;
      5'd9:  t = 30'd1073217664;
      5'd10: t = 30'd1072693760;
      5'd11: t = 30'd1071646719;
      5'd12: t = 30'd1069555701;
      5'd13: t = 30'd1065385899;
      5'd14: t = 30'd1057095000;
      5'd15: t = 30'd1040706261;
      5'd16: t = 30'd1008687096;
      5'd17: t = 30'd947573834;
      5'd18: t = 30'd836230973;
      5'd19: t = 30'd651257337;
      5'd20: t = 30'd395007542;
      5'd21: t = 30'd145315154;
      5'd22: t = 30'd19666268;
      5'd23: t = 30'd360200;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== src/multi_exp_model_with_gradient.sv =====
// ----------------------------------------------------------------------------
// multi_exp_model_with_gradient
// multi-exponential decay model with its partial derivatives, pipelined
// ----------------------------------------------------------------------------
// usage
//   input: raise start with time_value; the beat is taken when busy is low
//   config: cfg_valid / cfg_ready / cfg_index / cfg_data, write only while
//     idle (cfg_ready is always high)
//   results: 2n+2 beats per item on consecutive cycles, each marked by
//     strobe for one cycle, slot in order 0..2n+1, last on the final beat
//   path: capture, x * rate, exponent pipe, stages e, m1, m2, d1, d2, d3,
//     then the result sequencer and the registered result port
//   spacing: busy stays high after an accept while cool counts down, so
//     the beat bursts of items never overlap on the single result port
//   the datapath itself takes an item every cycle: 24 exponent stages, one
//     per bit of the scaled exponent, plus multiply and saturate stages
//   reset: synchronous, clears valid bits, counters and the registers to
//     num_terms = 2 and all coefficients zero
//   the receiver cannot stall; results are never held back
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_exp_model_with_gradient_macros.svh"
module multi_exp_model_with_gradient #(
  parameter int MAX_TERMS = mex_pkg::DEF_MAX_TERMS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [mex_pkg::X_W-1:0]   time_value,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [31:0]               cfg_data,
  output logic                           strobe,
  output logic [2:0]                     slot,
  output logic signed [mex_pkg::V_W-1:0] value,
  output logic                           last
);
  import mex_pkg::*;

  localparam int NS = EXP_BITS + 1;

  // configuration registers
  logic [1:0]                num_terms;
  logic signed [A_W-1:0]     offset;
  logic signed [A_W-1:0]     amp  [MAX_TERMS];
  logic [R_W-1:0]            rate [MAX_TERMS];

  // values derived from configuration, registered once per cycle
  logic [1:0]                n_eff;
  logic signed [SIG_W-1:0]   sig;
  logic [MAX_TERMS-1:0]      lane_on;
  logic [3:0]                total;

  logic                      accept;
  logic [3:0]                cool;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = (cool != 4'd0);

  // config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      num_terms <= 2'd2;
      offset    <= '0;
      for (int k = 0; k < MAX_TERMS; k++) begin
        amp[k]  <= '0;
        rate[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_NUM_TERMS) num_terms <= cfg_data[1:0];
      if (cfg_index == REG_OFFSET)    offset    <= cfg_data;
      for (int k = 0; k < MAX_TERMS; k++) begin
        if (cfg_index == 3'(REG_AMP0 + 2 * k))  amp[k]  <= cfg_data;
        if (cfg_index == 3'(REG_RATE0 + 2 * k)) rate[k] <= cfg_data[R_W-1:0];
      end
    end
  end

  // effective term count, common amplitude and per-lane enables
  always_ff @(posedge clk) begin
    logic signed [SIG_W-1:0] s;
    s = SIG_W'(amp[0]);
    for (int k = 1; k < MAX_TERMS; k++) begin
      if (2'(k) < n_eff) s = s - SIG_W'(amp[k]);
    end
    sig <= s;
    if (num_terms == 2'd0)               n_eff <= 2'd1;
    else if (num_terms > 2'(MAX_TERMS))  n_eff <= 2'(MAX_TERMS);
    else                                 n_eff <= num_terms;
    for (int k = 0; k < MAX_TERMS; k++) lane_on[k] <= (2'(k) < n_eff);
  end

  assign total = {1'b0, n_eff, 1'b0} + 4'd2;

  // accept spacing keeps the result port free of overlap
  always_ff @(posedge clk) begin
    if (rst)          cool <= '0;
    else if (accept)  cool <= total - 4'd1;
    else if (busy)    cool <= cool - 4'd1;
  end

  // stage 1: capture the sample time
  logic           v1;
  logic [X_W-1:0] x1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= accept;
    x1 <= time_value;
  end

  // stage 2: x * rate per lane
  logic           v2;
  logic [X_W-1:0] x2;
  logic [P_W-1:0] prod2 [MAX_TERMS];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    x2 <= x1;
    for (int k = 0; k < MAX_TERMS; k++) prod2[k] <= P_W'(x1) * P_W'(rate[k]);
  end

  // exponent pipe: stage 0 holds the rounded exponent, stage j+1 has
  // bit j folded into the accumulator
  logic                 vp  [NS];
  logic [X_W-1:0]       xp  [NS];
  logic [ACC_W-1:0]     acc_p [MAX_TERMS][NS];
  logic [EXP_BITS-1:0]  zb_p  [MAX_TERMS][NS];
  logic                 zr_p  [MAX_TERMS][NS];

  always_ff @(posedge clk) begin
    if (rst) vp[0] <= 1'b0;
    else     vp[0] <= v2;
    xp[0] <= x2;
  end

  for (genvar gk = 0; gk < MAX_TERMS; gk++) begin : g_zin
    logic [P_W:0] zf;
    assign zf = {1'b0, prod2[gk]} + (P_W+1)'(524288);
    always_ff @(posedge clk) begin
      zb_p[gk][0]  <= zf[EXP_BITS+19:20];
      zr_p[gk][0]  <= |zf[P_W:EXP_BITS+20];
      acc_p[gk][0] <= ACC_W'(1073741824);
    end
  end

  for (genvar gs = 0; gs < EXP_BITS; gs++) begin : g_exp
    always_ff @(posedge clk) begin
      if (rst) vp[gs+1] <= 1'b0;
      else     vp[gs+1] <= vp[gs];
      xp[gs+1] <= xp[gs];
    end
    for (genvar gl = 0; gl < MAX_TERMS; gl++) begin : g_lane
      logic [61:0] mul;
      assign mul = 62'(acc_p[gl][gs]) * 62'(exp_coef(5'(gs))) + 62'd536870912;
      always_ff @(posedge clk) begin
        zb_p[gl][gs+1]  <= zb_p[gl][gs];
        zr_p[gl][gs+1]  <= zr_p[gl][gs];
        acc_p[gl][gs+1] <= zb_p[gl][gs][gs] ? mul[ACC_W+29:30] : acc_p[gl][gs];
      end
    end
  end

  // stage e: round the accumulator to q20
  logic           v4;
  logic [X_W-1:0] x4;
  logic [E_W-1:0] e4 [MAX_TERMS];
  always_ff @(posedge clk) begin
    logic [ACC_W:0] r;
    if (rst) v4 <= 1'b0;
    else     v4 <= vp[NS-1];
    x4 <= xp[NS-1];
    for (int k = 0; k < MAX_TERMS; k++) begin
      r = {1'b0, acc_p[k][NS-1]} + (ACC_W+1)'(512);
      e4[k] <= zr_p[k][NS-1] ? '0 : r[E_W+9:10];
    end
  end

  // stage m1: amplitude times exponential
  logic                   v5;
  logic [X_W-1:0]         x5;
  logic [E_W-1:0]         e5  [MAX_TERMS];
  logic signed [MP_W-1:0] mp5 [MAX_TERMS];
  always_ff @(posedge clk) begin
    logic signed [SIG_W-1:0] a;
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    x5 <= x4;
    for (int k = 0; k < MAX_TERMS; k++) begin
      a = (k == 0) ? sig : SIG_W'(amp[k]);
      e5[k]  <= e4[k];
      mp5[k] <= a * $signed({1'b0, e4[k]});
    end
  end

  // stage m2: back to q20, idle lanes forced to zero
  logic                  v6;
  logic [X_W-1:0]        x6;
  logic [E_W-1:0]        e6 [MAX_TERMS];
  logic signed [M_W-1:0] m6 [MAX_TERMS];
  always_ff @(posedge clk) begin
    logic signed [MP_W-1:0] t;
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
    x6 <= x5;
    for (int k = 0; k < MAX_TERMS; k++) begin
      t = (mp5[k] + MP_W'(524288)) >>> 20;
      e6[k] <= e5[k];
      m6[k] <= lane_on[k] ? t[M_W-1:0] : '0;
    end
  end

  // stage d1: model sum, split products for the rate derivatives
  logic                    v7;
  logic [E_W-1:0]          e7   [MAX_TERMS];
  logic signed [Y_W-1:0]   ys7;
  logic [PLO_W-1:0]        plo7 [MAX_TERMS];
  logic signed [PHI_W-1:0] phi7 [MAX_TERMS];
  always_ff @(posedge clk) begin
    logic signed [Y_W-1:0] s;
    if (rst) v7 <= 1'b0;
    else     v7 <= v6;
    s = Y_W'(offset);
    for (int k = 0; k < MAX_TERMS; k++) begin
      s = s + Y_W'(m6[k]);
      e7[k]   <= e6[k];
      plo7[k] <= PLO_W'(x6) * PLO_W'(m6[k][ML_W-1:0]);
      phi7[k] <= $signed({1'b0, x6}) * $signed(m6[k][M_W-1:ML_W]);
    end
    ys7 <= s;
  end

  function automatic logic signed [V_W-1:0] sat_y(input logic signed [Y_W-1:0] v);
    if (v > Y_W'(64'sd2147483647))       return 32'sh7fffffff;
    else if (v < -Y_W'(64'sd2147483648)) return 32'sh80000000;
    else                                 return v[V_W-1:0];
  endfunction

  function automatic logic signed [V_W-1:0] sat_d(input logic signed [D_W-1:0] v);
    if (v > D_W'(64'sd2147483647))       return 32'sh7fffffff;
    else if (v < -D_W'(64'sd2147483648)) return 32'sh80000000;
    else                                 return v[V_W-1:0];
  endfunction

  // stage d2: saturate the model value, join the partial products
  logic                   v8;
  logic [E_W-1:0]         e8  [MAX_TERMS];
  logic signed [V_W-1:0]  y8;
  logic signed [DP_W-1:0] dp8 [MAX_TERMS];
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else     v8 <= v7;
    y8 <= sat_y(ys7);
    for (int k = 0; k < MAX_TERMS; k++) begin
      e8[k]  <= e7[k];
      dp8[k] <= (DP_W'(phi7[k]) <<< ML_W) + $signed({{(DP_W-PLO_W){1'b0}}, plo7[k]});
    end
  end

  // stage d3: negate, round and saturate the rate derivatives
  logic                  v9;
  logic [E_W-1:0]        e9 [MAX_TERMS];
  logic signed [V_W-1:0] y9;
  logic signed [V_W-1:0] d9 [MAX_TERMS];
  always_ff @(posedge clk) begin
    logic signed [DP_W-1:0] t;
    if (rst) v9 <= 1'b0;
    else     v9 <= v8;
    y9 <= y8;
    for (int k = 0; k < MAX_TERMS; k++) begin
      t = ((-dp8[k]) + DP_W'(524288)) >>> 20;
      e9[k] <= e8[k];
      d9[k] <= sat_d(t[D_W-1:0]);
    end
  end

  // result sequencer: holds one item, walks the slots one beat a cycle
  logic                  active;
  logic [2:0]            idx;
  logic [3:0]            total_h;
  logic [E_W-1:0]        eh [MAX_TERMS];
  logic signed [V_W-1:0] dh [MAX_TERMS];
  logic signed [V_W-1:0] yh;
  logic signed [V_W-1:0] value_next;
  logic                  at_end;

  assign at_end = ({1'b0, idx} == total_h - 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (v9) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (active) begin
      if (at_end) active <= 1'b0;
      else        idx    <= idx + 3'd1;
    end
    if (v9) begin
      yh      <= y9;
      total_h <= total;
      for (int k = 0; k < MAX_TERMS; k++) begin
        eh[k] <= e9[k];
        dh[k] <= d9[k];
      end
    end
  end

  always_comb begin
    logic signed [E_W:0] df;
    df         = '0;
    value_next = '0;
    unique case (idx)
      SLOT_Y:      value_next = yh;
      SLOT_DOFS:   value_next = ONE_Q20;
      SLOT_DAMP0:  value_next = {{(V_W-E_W){1'b0}}, eh[0]};
      SLOT_DRATE0: value_next = dh[0];
      default: begin
        for (int k = 1; k < MAX_TERMS; k++) begin
          df = $signed({1'b0, eh[k]}) - $signed({1'b0, eh[0]});
          if (idx == 3'(2 * k + 2)) value_next = {{(V_W-E_W-1){df[E_W]}}, df};
          if (idx == 3'(2 * k + 3)) value_next = dh[k];
        end
      end
    endcase
  end

  // registered result port
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      strobe <= active;
      last   <= active && at_end;
    end
    slot  <= idx;
    value <= value_next;
  end

  // checks
  `MEX_ASSERT_NEXT(a_busy_after_accept, clk, rst, start && !busy, busy)
  `MEX_ASSERT_SAME(a_last_with_strobe, clk, rst, last, strobe)
  `MEX_ASSERT_NEXT(a_burst_unbroken, clk, rst, strobe && !last, strobe)

endmodule
`default_nettype wire

// ===== verif/mex_checker.sv =====
// ----------------------------------------------------------------------------
// mex_checker
// tracks register writes, predicts every result beat and compares in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mex_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [30:0] time_value,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        strobe,
  input  wire logic [2:0]  slot,
  input  wire logic [31:0] value,
  input  wire logic        last,
  output int               errors,
  output int               pending
);
  import mex_pkg::*;

  typedef struct {
    logic [2:0]  slot;
    logic [31:0] value;
    logic        last;
  } beat_t;

  const longint unsigned decay_tab [24] = '{
    1073740800, 1073739776, 1073737728, 1073733632,
    1073725440, 1073708544, 1073676290, 1073610760,
    1073479712, 1073217664, 1072693760, 1071646719,
    1069555701, 1065385899, 1057095000, 1040706261,
    1008687096, 947573834, 836230973, 651257337,
    395007542, 145315154, 19666268, 360200};

  beat_t       beat_q[$];
  logic [1:0]  term_cnt;
  longint      ofs;
  longint      amp [3];
  longint unsigned rate [3];

  assign pending = beat_q.size();

  function automatic longint decay(longint unsigned x, longint unsigned r);
    longint unsigned z, acc;
    z = (x * r + 64'd524288) >> 20;
    if (z >= (64'd16 << 20)) return 0;
    acc = 64'd1 << 30;
    for (int b = 0; b < 24; b++)
      if (z[b]) acc = (acc * decay_tab[b] + 64'd536870912) >> 30;
    return longint'((acc + 64'd512) >> 10);
  endfunction

  function automatic longint to_q20(longint v);
    return (v + 64'sd524288) >>> 20;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // sat(round(-(x*m))), saturating by sign once the product passes 2^62
  function automatic longint slope(longint unsigned x, longint m);
    longint unsigned mag;
    longint p;
    mag = (m < 0) ? longint'(-m) : longint'(m);
    if (x != 0 && mag > (64'd1 << 62) / x)
      return (m < 0) ? 64'sd2147483647 : -64'sd2147483648;
    p = longint'(x * mag);
    return clamp32(to_q20((m < 0) ? p : -p));
  endfunction

  function automatic void predict_item(logic [30:0] xv);
    longint unsigned x;
    longint e [3];
    longint m [3];
    longint sig, y;
    int n, total, cnt;
    logic [2:0] s [8];
    longint v [8];
    x = xv;
    n = (term_cnt == 0) ? 1 : int'(term_cnt);
    total = 2 * n + 2;
    sig = amp[0];
    for (int k = 0; k < n; k++) e[k] = decay(x, rate[k]);
    for (int k = 1; k < n; k++) begin
      sig -= amp[k];
      m[k] = to_q20(amp[k] * e[k]);
    end
    m[0] = to_q20(sig * e[0]);
    y = ofs + m[0];
    for (int k = 1; k < n; k++) y += m[k];
    s[0] = SLOT_Y;      v[0] = clamp32(y);
    s[1] = SLOT_DOFS;   v[1] = longint'(ONE_Q20);
    s[2] = SLOT_DAMP0;  v[2] = e[0];
    s[3] = SLOT_DRATE0; v[3] = slope(x, m[0]);
    cnt = 4;
    for (int k = 1; k < n; k++) begin
      s[cnt] = 3'(2 * k + 2); v[cnt] = e[k] - e[0];      cnt++;
      s[cnt] = 3'(2 * k + 3); v[cnt] = slope(x, m[k]);   cnt++;
    end
    for (int i = 0; i < total; i++)
      beat_q.push_back('{slot: s[i], value: v[i][31:0], last: (i == total - 1)});
  endfunction

  always @(posedge clk) begin
    beat_t exp_b;
    if (rst) begin
      term_cnt <= 2'd2;
      ofs = 0;
      for (int k = 0; k < 3; k++) begin
        amp[k] = 0;
        rate[k] = 0;
      end
      beat_q.delete();
      errors <= 0;
    end else begin
      if (strobe) begin
        if (beat_q.size() == 0) begin
          $error("result beat slot %0d with nothing expected", slot);
          errors <= errors + 1;
        end else begin
          exp_b = beat_q.pop_front();
          if (slot !== exp_b.slot || value !== exp_b.value || last !== exp_b.last)
            errors <= errors + 1;
          if (slot !== exp_b.slot)
            $error("slot: expected %0d, got %0d", exp_b.slot, slot);
          if (value !== exp_b.value)
            $error("value: expected %0d, got %0d", $signed(exp_b.value), $signed(value));
          if (last !== exp_b.last)
            $error("last: expected %0d, got %0d", exp_b.last, last);
        end
      end
      if (start && !busy) predict_item(time_value);
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_NUM_TERMS: term_cnt <= cfg_data[1:0];
          REG_OFFSET:    ofs = longint'($signed(cfg_data));
          REG_AMP0:      amp[0] = longint'($signed(cfg_data));
          REG_RATE0:     rate[0] = cfg_data[30:0];
          REG_AMP1:      amp[1] = longint'($signed(cfg_data));
          REG_RATE1:     rate[1] = cfg_data[30:0];
          REG_AMP2:      amp[2] = longint'($signed(cfg_data));
          REG_RATE2:     rate[2] = cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives samples and register settings into the multi-exponential model;
// the checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import mex_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [30:0] time_value = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        strobe;
  logic [2:0]  slot;
  logic signed [31:0] value;
  logic        last;
  int          errors;
  int          pending;
  bit          steady;   // no input gaps while set

  always #5 clk = ~clk;

  multi_exp_model_with_gradient i_dut (
    .clk, .rst, .start, .busy, .time_value, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .strobe, .slot, .value, .last
  );

  mex_checker i_checker (
    .clk, .rst, .start, .busy, .time_value, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .strobe, .slot, .value, .last, .errors, .pending
  );

  // random value with a random magnitude, so small and huge values both occur
  function automatic logic [31:0] rand_mag();
    int w;
    w = $urandom_range(32, 0);
    return (w == 32) ? $urandom : ($urandom & ((32'd1 << w) - 1));
  endfunction

  // one register write beat
  task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one sample beat; start stays high across back-to-back beats
  task automatic send_sample(logic [30:0] x);
    if (!steady && $urandom_range(99, 0) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    start <= 1'b1;
    time_value <= x;
    do @(posedge clk); while (busy);
  endtask

  // registers change only with nothing in flight
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_all(logic [1:0] n, logic [31:0] ofs, logic [31:0] a0,
                         logic [30:0] r0, logic [31:0] a1, logic [30:0] r1,
                         logic [31:0] a2, logic [30:0] r2);
    write_reg(REG_NUM_TERMS, {30'd0, n});
    write_reg(REG_OFFSET, ofs);
    write_reg(REG_AMP0, a0);
    write_reg(REG_RATE0, {1'b0, r0});
    write_reg(REG_AMP1, a1);
    write_reg(REG_RATE1, {1'b0, r1});
    write_reg(REG_AMP2, a2);
    write_reg(REG_RATE2, {1'b0, r2});
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, then the edges of every field
    steady = 1'b1;
    send_sample(31'd0);
    send_sample(31'h7fffffff);
    drain();
    // zero term count acts as one term; zero rate gives e = 1.0
    set_all(2'd0, 32'h7fffffff, 32'h7fffffff, 31'd0, 32'h80000000, 31'd0,
            32'h80000000, 31'd0);
    send_sample(31'd0);
    send_sample(31'd1);
    send_sample(31'h7fffffff);   // huge product saturates the slope
    drain();
    // three terms, opposite extremes, saturated sum
    set_all(2'd3, 32'h80000000, 32'h80000000, 31'd1, 32'h7fffffff, 31'd1048576,
            32'h7fffffff, 31'h7fffffff);
    send_sample(31'd0);
    send_sample(31'd1);
    send_sample(31'd1048576);
    send_sample(31'd16 << 20);   // exponent cut to zero at 16 and above
    send_sample(31'h7fffffff);
    drain();
    set_all(2'd1, 32'd0, 32'h00100000, 31'd524288, 32'h7fffffff, 31'd0,
            32'd0, 31'd0);
    send_sample(31'd2 << 20);
    send_sample(31'h00ffffff);
    drain();
    set_all(2'd2, 32'h12345678, 32'hfff00000, 31'd3 << 20, 32'h00400000,
            31'd1 << 18, 32'd5, 31'd7);
    send_sample(31'd1 << 19);
    send_sample(31'd5 << 20);
    drain();

    // random phases: fresh registers each time, gaps except in one stretch
    for (int ph = 0; ph < 10; ph++) begin
      set_all(2'($urandom), rand_mag() ^ {1'($urandom_range(1, 0)), 31'd0},
              rand_mag() ^ {1'($urandom_range(1, 0)), 31'd0}, 31'(rand_mag()),
              rand_mag() ^ {1'($urandom_range(1, 0)), 31'd0}, 31'(rand_mag()),
              rand_mag() ^ {1'($urandom_range(1, 0)), 31'd0}, 31'(rand_mag()));
      steady = (ph == 4);
      for (int i = 0; i < 22; i++) send_sample(31'(rand_mag()));
      drain();
    end

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
